/* sv/lgg_pkg.sv */
// shared types, constants and arithmetic helpers for the lateral offset goal generator
package lgg_pkg;

  localparam int MAX_PATHS          = 16;
  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int CW                 = 34;
  localparam int NMAX               = (MAX_PATHS < 16) ? MAX_PATHS : 16;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sh026DD3B6A;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PATHS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAT_SPACING = 2'd1;

  typedef struct packed {
    logic               action;
    logic signed [31:0] ego_x;
    logic signed [31:0] ego_y;
    logic signed [31:0] ego_z;
    logic signed [15:0] ego_yaw;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [15:0] goal_yaw;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] out_yaw;
    logic [3:0]         path_index;
    logic               last;
  } out_t;

  function automatic logic [31:0] atan_val(input int unsigned k);
    logic [31:0] r;
    case (k)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // round half up from q2.30 scaling, then saturate
  function automatic logic signed [31:0] rnd_sat(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = (v + 68'sd536870912) >>> 30;
    return sat32(t);
  endfunction

endpackage

/* sv/lgg_cordic.sv */
// pipelined rotation-mode cordic producing cosine and sine of a binary angle
module lgg_cordic import lgg_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          ang,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  logic signed [CW-1:0] x_r [0:STAGES];
  logic signed [CW-1:0] y_r [0:STAGES];
  logic signed [CW-1:0] z_r [0:STAGES];
  logic                 f_r [0:STAGES];

  logic signed [31:0] a32;
  logic               pre;
  logic [31:0]        za;

  always_comb begin
    a32 = {ang, 16'h0000};
    pre = (a32 > 32'sd1073741824) || (a32 < -32'sd1073741824);
    // fold into the right half plane, undone by negating the result
    za  = pre ? {~ang[15], ang[14:0], 16'h0000} : {ang, 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_X0;
      y_r[0] <= '0;
      z_r[0] <= CW'(signed'(za));
      f_r[0] <= pre;
    end
  end

  genvar k;
  generate
    for (k = 0; k < STAGES; k++) begin : g_stage
      logic signed [CW-1:0] at;
      assign at = CW'(atan_val(k));
      always_ff @(posedge clk) begin
        if (en) begin
          if (!z_r[k][CW-1]) begin
            x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
            y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
            z_r[k+1] <= z_r[k] - at;
          end else begin
            x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
            y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
            z_r[k+1] <= z_r[k] + at;
          end
          f_r[k+1] <= f_r[k];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= f_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
      sin_o <= f_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];
    end
  end

endmodule

/* sv/lateral_offset_goal_generator.sv */
// lateral offset goal generator top level
//
//  channel | ports                          | carries
//  in      | in_valid in_ready in_data      | ego pose, goal pose, action
//  out     | out_valid out_ready out_data   | one offset goal per item
//  cfg     | cfg_valid cfg_ready cfg_index  | num_paths, lateral spacing writes
//          | cfg_data                       |
//
// a request occupies the expander for n offset goals, n = clamped num_paths, and
// issues none when num_paths or spacing is zero; one offset goal per cycle while
// out_ready does not hold the back end.
// reset is synchronous, clears valid bits and expander state, and loads config defaults.
// out_ready low holds the expander and back end; the front end keeps filling
// until a request waits at the expander. nothing is dropped or repeated.
module lateral_offset_goal_generator import lgg_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int L = CORDIC_STAGES + 2;

  typedef struct packed {
    logic               action;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [15:0]        gyaw;
    logic [15:0]        eyaw;
  } dif_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        yaw;
  } pose_t;

  // config registers
  logic [4:0]  num_paths_r;
  logic [15:0] lat_spacing_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_paths_r   <= 5'd7;
      lat_spacing_r <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_PATHS:   num_paths_r   <= cfg_data[4:0];
        CFG_LAT_SPACING: lat_spacing_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic f_en, b_en;

  // input register
  logic a_v_r;
  in_t  a_d_r;

  assign in_ready = f_en;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (f_en) a_v_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (f_en) a_d_r <= in_data;
  end

  // translation, then wait alongside the ego-yaw cordic
  dif_t d_nxt;
  always_comb begin
    d_nxt.action = a_d_r.action;
    d_nxt.gx     = a_d_r.goal_x;
    d_nxt.gy     = a_d_r.goal_y;
    d_nxt.gz     = a_d_r.goal_z;
    d_nxt.dx     = sat32(68'(a_d_r.goal_x) - 68'(a_d_r.ego_x));
    d_nxt.dy     = sat32(68'(a_d_r.goal_y) - 68'(a_d_r.ego_y));
    d_nxt.dz     = sat32(68'(a_d_r.goal_z) - 68'(a_d_r.ego_z));
    d_nxt.gyaw   = a_d_r.goal_yaw;
    d_nxt.eyaw   = a_d_r.ego_yaw;
  end

  logic d1_v_r [1:L];
  dif_t d1_r   [1:L];

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r[1] <= 1'b0;
    else if (f_en) d1_v_r[1] <= a_v_r;
  end
  always_ff @(posedge clk) begin
    if (f_en) d1_r[1] <= d_nxt;
  end

  genvar k;
  generate
    for (k = 2; k <= L; k++) begin : g_dl1
      always_ff @(posedge clk) begin
        if (!rst_n) d1_v_r[k] <= 1'b0;
        else if (f_en) d1_v_r[k] <= d1_v_r[k-1];
      end
      always_ff @(posedge clk) begin
        if (f_en) d1_r[k] <= d1_r[k-1];
      end
    end
  endgenerate

  logic signed [CW-1:0] c1, s1;

  lgg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ego (
    .clk   (clk),
    .en    (f_en),
    .ang   (a_d_r.ego_yaw),
    .cos_o (c1),
    .sin_o (s1)
  );

  // rotation by minus ego yaw: sine negated
  logic               m_v_r;
  dif_t               m_d_r;
  logic signed [65:0] m_pa_r, m_pb_r, m_pc_r, m_pd_r;
  logic signed [CW-1:0] ns1;
  assign ns1 = -s1;

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else if (f_en) m_v_r <= d1_v_r[L];
  end
  always_ff @(posedge clk) begin
    if (f_en) begin
      m_d_r  <= d1_r[L];
      m_pa_r <= 66'(c1)  * 66'(d1_r[L].dx);
      m_pb_r <= 66'(ns1) * 66'(d1_r[L].dy);
      m_pc_r <= 66'(ns1) * 66'(d1_r[L].dx);
      m_pd_r <= 66'(c1)  * 66'(d1_r[L].dy);
    end
  end

  logic  r_v_r;
  pose_t r_g_r, r_g_nxt;

  always_comb begin
    if (m_d_r.action) begin
      r_g_nxt.x   = rnd_sat(68'(m_pa_r) - 68'(m_pb_r));
      r_g_nxt.y   = rnd_sat(68'(m_pc_r) + 68'(m_pd_r));
      r_g_nxt.z   = m_d_r.dz;
      r_g_nxt.yaw = m_d_r.gyaw - m_d_r.eyaw;
    end else begin
      r_g_nxt.x   = m_d_r.gx;
      r_g_nxt.y   = m_d_r.gy;
      r_g_nxt.z   = m_d_r.gz;
      r_g_nxt.yaw = m_d_r.gyaw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) r_v_r <= 1'b0;
    else if (f_en) r_v_r <= m_v_r;
  end
  always_ff @(posedge clk) begin
    if (f_en) r_g_r <= r_g_nxt;
  end

  // heading plus a quarter turn gives the lateral direction
  logic  g2_v_r [1:L];
  pose_t g2_r   [1:L];

  always_ff @(posedge clk) begin
    if (!rst_n) g2_v_r[1] <= 1'b0;
    else if (f_en) g2_v_r[1] <= r_v_r;
  end
  always_ff @(posedge clk) begin
    if (f_en) g2_r[1] <= r_g_r;
  end

  generate
    for (k = 2; k <= L; k++) begin : g_dl2
      always_ff @(posedge clk) begin
        if (!rst_n) g2_v_r[k] <= 1'b0;
        else if (f_en) g2_v_r[k] <= g2_v_r[k-1];
      end
      always_ff @(posedge clk) begin
        if (f_en) g2_r[k] <= g2_r[k-1];
      end
    end
  endgenerate

  logic signed [CW-1:0] c2, s2;
  logic [15:0]          lat_ang;
  assign lat_ang = r_g_r.yaw + 16'h4000;

  lgg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (
    .clk   (clk),
    .en    (f_en),
    .ang   (lat_ang),
    .cos_o (c2),
    .sin_o (s2)
  );

  // expander: holds one request and issues its offset goals
  logic                 e_busy_r;
  pose_t                e_g_r;
  logic signed [CW-1:0] e_c_r, e_s_r;
  logic [4:0]           e_i_r, e_n_r;
  logic [3:0]           e_half_r;
  logic [4:0]           n_eff;
  logic                 issue, last_issue, free;

  assign n_eff      = (num_paths_r > 5'(NMAX)) ? 5'(NMAX) : num_paths_r;
  assign issue      = e_busy_r && b_en;
  assign last_issue = issue && (e_i_r == e_n_r - 5'd1);
  assign free       = !e_busy_r || last_issue;
  assign f_en       = !g2_v_r[L] || free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_busy_r <= 1'b0;
      e_i_r    <= '0;
    end else if (g2_v_r[L] && free) begin
      e_busy_r <= (n_eff != 5'd0) && (lat_spacing_r != 16'd0);
      e_i_r    <= '0;
    end else if (issue) begin
      if (last_issue) e_busy_r <= 1'b0;
      e_i_r <= e_i_r + 5'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (g2_v_r[L] && free) begin
      e_g_r    <= g2_r[L];
      e_c_r    <= c2;
      e_s_r    <= s2;
      e_n_r    <= n_eff;
      e_half_r <= n_eff[4:1];
    end
  end

  // back end: offset, products, sum and saturate
  assign b_en = !out_valid || out_ready;

  logic signed [5:0]  idx;
  logic signed [21:0] off_nxt;
  assign idx     = $signed({1'b0, e_i_r}) - $signed({2'b00, e_half_r});
  assign off_nxt = 22'(idx) * $signed({6'b0, lat_spacing_r});

  logic                 b1_v_r;
  logic signed [21:0]   b1_off_r;
  pose_t                b1_g_r;
  logic signed [CW-1:0] b1_c_r, b1_s_r;
  logic [3:0]           b1_i_r;
  logic                 b1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b1_v_r <= 1'b0;
    else if (b_en) b1_v_r <= issue;
  end
  always_ff @(posedge clk) begin
    if (b_en) begin
      b1_off_r  <= off_nxt;
      b1_g_r    <= e_g_r;
      b1_c_r    <= e_c_r;
      b1_s_r    <= e_s_r;
      b1_i_r    <= e_i_r[3:0];
      b1_last_r <= (e_i_r == e_n_r - 5'd1);
    end
  end

  logic               b2_v_r;
  logic signed [55:0] b2_px_r, b2_py_r;
  pose_t              b2_g_r;
  logic [3:0]         b2_i_r;
  logic               b2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b2_v_r <= 1'b0;
    else if (b_en) b2_v_r <= b1_v_r;
  end
  always_ff @(posedge clk) begin
    if (b_en) begin
      b2_px_r   <= 56'(b1_off_r) * 56'(b1_c_r);
      b2_py_r   <= 56'(b1_off_r) * 56'(b1_s_r);
      b2_g_r    <= b1_g_r;
      b2_i_r    <= b1_i_r;
      b2_last_r <= b1_last_r;
    end
  end

  logic signed [31:0] rx, ry;
  assign rx = rnd_sat(68'(b2_px_r));
  assign ry = rnd_sat(68'(b2_py_r));

  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (b_en) out_valid_r <= b2_v_r;
  end
  always_ff @(posedge clk) begin
    if (b_en) begin
      out_data_r.out_x      <= sat32(68'(b2_g_r.x) + 68'(rx));
      out_data_r.out_y      <= sat32(68'(b2_g_r.y) + 68'(ry));
      out_data_r.out_z      <= b2_g_r.z;
      out_data_r.out_yaw    <= b2_g_r.yaw;
      out_data_r.path_index <= b2_i_r;
      out_data_r.last       <= b2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
